>>> sv/nss_pkg.sv
// Shared constants for the nine-slice source address generator.
`default_nettype none

package nss_pkg;

    // Largest supported image dimension in pixels
    localparam int MAX_DIM = 4096;

    // Size registers hold 0..8191, which covers 0..MAX_DIM
    localparam int SZ_W = $clog2(MAX_DIM) + 1;
    // Pixel coordinates
    localparam int CO_W = 12;
    // Border piece, centre size and remainder
    localparam int PC_W = $clog2(MAX_DIM / 3 + 2);

    // Divide by three as multiply by reciprocal, exact for values below 2**SZ_W
    localparam int RECIP_SH = SZ_W + 1;
    localparam int RECIP_W  = SZ_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH + 2) / 3);

    // Size limits
    localparam logic [SZ_W-1:0] SRC_MIN = SZ_W'(3);
    localparam logic [SZ_W-1:0] DIM_MAX = SZ_W'(MAX_DIM);

    // Configuration register indexes
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [IDX_W-1:0] REG_TGT_W = 2'd2;
    localparam logic [IDX_W-1:0] REG_TGT_H = 2'd3;

    // Stages inside one axis: capture, piece, classify, then one per remainder bit
    localparam int AXIS_STAGES = 3 + CO_W;

endpackage

`default_nettype wire

>>> sv/nss_axis.sv
// One axis of the nine-slice mapping: piece size, edge classes and tiled remainder.
`default_nettype none

module nss_axis (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [nss_pkg::SZ_W-1:0]   i_src_sz,
    input  wire logic [nss_pkg::SZ_W-1:0]   i_dst_sz,
    input  wire logic [nss_pkg::CO_W-1:0]   i_coord,
    output logic      [nss_pkg::CO_W-1:0]   o_src
);
    import nss_pkg::*;

    // Stage A: capture sizes and coordinate
    logic [SZ_W-1:0] r_a_s, r_a_d;
    logic [CO_W-1:0] r_a_o;

    // Stage B: border piece
    logic [SZ_W-1:0] r_b_s, r_b_d;
    logic [CO_W-1:0] r_b_o;
    logic [PC_W-1:0] r_b_p;
    logic [SZ_W+RECIP_W-1:0] w_prod;

    // Stage C outputs and remainder stages share index 0..CO_W
    logic [PC_W-1:0] r_p   [CO_W+1];
    logic [PC_W-1:0] r_c   [CO_W+1];
    logic [PC_W-1:0] r_rem [CO_W+1];
    logic [CO_W-1:0] r_num [CO_W+1];
    logic [CO_W-1:0] r_alt [CO_W+1];
    logic            r_mid [CO_W+1];

    // Stage C combinational terms
    logic [SZ_W-1:0] w_two_p;
    logic [SZ_W-1:0] w_d;
    logic [SZ_W-1:0] w_far_val;
    logic            w_far;
    logic            w_near;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_s <= i_src_sz;
            r_a_d <= i_dst_sz;
            r_a_o <= i_coord;
        end
    end

    // Piece = (S + 1) / 3
    assign w_prod = (SZ_W+RECIP_W)'(r_a_s + SZ_W'(1)) * (SZ_W+RECIP_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_s <= r_a_s;
            r_b_d <= r_a_d;
            r_b_o <= r_a_o;
            r_b_p <= w_prod[RECIP_SH +: PC_W];
        end
    end

    // Crop, edge tests and far-edge address
    always_comb begin
        w_two_p   = SZ_W'({r_b_p, 1'b0});
        w_d       = (r_b_d < w_two_p) ? ((w_two_p - r_b_d) >> 1) : '0;
        w_far     = ((SZ_W+1)'(r_b_o) + (SZ_W+1)'(r_b_p)) >=
                    ((SZ_W+1)'(r_b_d) + (SZ_W+1)'(w_d));
        w_near    = ((SZ_W+1)'(r_b_o) + (SZ_W+1)'(w_d)) < (SZ_W+1)'(r_b_p);
        w_far_val = r_b_s - r_b_d + SZ_W'(r_b_o);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]   <= r_b_p;
            r_c[0]   <= PC_W'(r_b_s - w_two_p);
            r_rem[0] <= '0;
            r_num[0] <= r_b_o - CO_W'(r_b_p);
            r_alt[0] <= w_far ? w_far_val[CO_W-1:0] : r_b_o;
            r_mid[0] <= !w_far && !w_near;
        end
    end

    // Remainder of (o - piece) by centre, one numerator bit per stage
    for (genvar g = 0; g < CO_W; g++) begin : g_mod
        logic [PC_W:0] w_t;
        logic          w_ge;

        assign w_t  = {r_rem[g], r_num[g][CO_W-1-g]};
        assign w_ge = w_t >= {1'b0, r_c[g]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[g+1]   <= r_p[g];
                r_c[g+1]   <= r_c[g];
                r_rem[g+1] <= w_ge ? PC_W'(w_t - {1'b0, r_c[g]}) : w_t[PC_W-1:0];
                r_num[g+1] <= r_num[g];
                r_alt[g+1] <= r_alt[g];
                r_mid[g+1] <= r_mid[g];
            end
        end
    end

    // Pick tiled centre or edge address
    assign o_src = r_mid[CO_W] ? (CO_W'(r_p[CO_W]) + CO_W'(r_rem[CO_W])) : r_alt[CO_W];

endmodule

`default_nettype wire

>>> sv/nine_slice_source_address.sv
// Nine-slice source address generator, top level with size registers and pipeline control.
// The result passes through 15 datapath stages, then the output register.
// One word per cycle unless stalled; centre remainder runs one bit per stage, 12 stages.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the size registers
// with source 3x3 and target 1x1.
`default_nettype none

module nine_slice_source_address (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Size register write port
    input  wire logic                         i_cfg_we,
    input  wire logic [nss_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [nss_pkg::SZ_W-1:0]     i_cfg_data,
    // Destination coordinate in
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [nss_pkg::CO_W-1:0]     i_dest_x,
    input  wire logic [nss_pkg::CO_W-1:0]     i_dest_y,
    // Source address out
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [nss_pkg::CO_W-1:0]     o_src_x,
    output logic      [nss_pkg::CO_W-1:0]     o_src_y,
    output logic                              o_inside_res
);
    import nss_pkg::*;

    logic [SZ_W-1:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [SZ_W-1:0] w_sw, w_sh, w_tw, w_th;
    logic            w_adv;
    logic            w_inside;
    logic [CO_W-1:0] w_ax_x, w_ax_y;

    logic            r_vld [AXIS_STAGES];
    logic            r_ins [AXIS_STAGES];
    logic            r_out_valid;
    logic [CO_W-1:0] r_src_x, r_src_y;
    logic            r_inside;

    // Write size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_MIN;
            r_src_h <= SRC_MIN;
            r_tgt_w <= SZ_W'(1);
            r_tgt_h <= SZ_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_W: r_src_w <= i_cfg_data;
                REG_SRC_H: r_src_h <= i_cfg_data;
                REG_TGT_W: r_tgt_w <= i_cfg_data;
                REG_TGT_H: r_tgt_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes to the supported range
    always_comb begin
        w_sw = (r_src_w < SRC_MIN) ? SRC_MIN : ((r_src_w > DIM_MAX) ? DIM_MAX : r_src_w);
        w_sh = (r_src_h < SRC_MIN) ? SRC_MIN : ((r_src_h > DIM_MAX) ? DIM_MAX : r_src_h);
        w_tw = (r_tgt_w > DIM_MAX) ? DIM_MAX : r_tgt_w;
        w_th = (r_tgt_h > DIM_MAX) ? DIM_MAX : r_tgt_h;
        w_inside = (SZ_W'(i_dest_x) < w_tw) && (SZ_W'(i_dest_y) < w_th);
    end

    // Advance the pipeline whenever the output register is free or being taken
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    nss_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_src_sz (w_sw),
        .i_dst_sz (w_tw),
        .i_coord  (i_dest_x),
        .o_src    (w_ax_x)
    );

    nss_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_src_sz (w_sh),
        .i_dst_sz (w_th),
        .i_coord  (i_dest_y),
        .o_src    (w_ax_y)
    );

    // Carry valid and inside flags along with the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXIS_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < AXIS_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ins[0] <= w_inside;
            for (int k = 1; k < AXIS_STAGES; k++) begin
                r_ins[k] <= r_ins[k-1];
            end
        end
    end

    // Output register; outside the target gives address zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_vld[AXIS_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_inside <= r_ins[AXIS_STAGES-1];
            r_src_x  <= r_ins[AXIS_STAGES-1] ? w_ax_x : '0;
            r_src_y  <= r_ins[AXIS_STAGES-1] ? w_ax_y : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_src_x      = r_src_x;
    assign o_src_y      = r_src_y;
    assign o_inside_res = r_inside;

endmodule

`default_nettype wire
